// ===== hw/rtl/sfvs_pkg.sv =====
// Shared types, constants and helpers for the skew-fair victim selector.
// Used by sfvs_lane, sfvs_merge and skew_fair_victim_select_core.
`timescale 1ns / 1ps

package sfvs_pkg;

  // Cache geometry
  localparam int Ways  = 16;
  localparam int Skews = 2;

  // Field widths of the request and result items
  localparam int MaskW    = 16;
  localparam int RandW    = 4;
  localparam int OutWayW  = 4;
  localparam int OutSkewW = 1;

  // Derived sizes
  localparam int SkewSize = (Ways / Skews == 0) ? 1 : Ways / Skews;
  localparam int CntW     = $clog2(SkewSize + 1);
  localparam int OffW     = (SkewSize > 1) ? $clog2(SkewSize) : 1;
  localparam int WayIdxW  = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int SkewIdxW = (Skews > 1) ? $clog2(Skews) : 1;

  // What one lane reports about its skew
  typedef struct packed {
    logic [CntW-1:0] cnt;   // invalid ways in the skew
    logic [OffW-1:0] off;   // offset of the lowest invalid way
  } lane_t;

  // Merged decision
  typedef struct packed {
    logic [OutWayW-1:0]  victim;
    logic                took;
    logic [OutSkewW-1:0] skew;
  } res_t;

  // Wrap the random way into range: small constant table over the random field.
  function automatic logic [WayIdxW-1:0] rnd_wrap(input logic [RandW-1:0] r);
    logic [WayIdxW-1:0] res;
    res = '0;
    for (int k = 0; k < (1 << RandW); k++) begin
      if (r == RandW'(k)) res = WayIdxW'(k % Ways);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/sfvs_lane.sv =====
// One skew lane: counts invalid ways and finds the lowest invalid way.
// Depends on sfvs_pkg.
`timescale 1ns / 1ps

module sfvs_lane (
  input  logic [sfvs_pkg::SkewSize-1:0] mask_i,
  output sfvs_pkg::lane_t               lane_o
);

  logic [sfvs_pkg::CntW-1:0] cnt;
  logic [sfvs_pkg::OffW-1:0] off;
  logic                      found;

  always_comb begin
    cnt   = '0;
    off   = '0;
    found = 1'b0;
    for (int j = 0; j < sfvs_pkg::SkewSize; j++) begin
      cnt = cnt + sfvs_pkg::CntW'(!mask_i[j]);
      // keep the first invalid way
      if (!mask_i[j] && !found) begin
        off   = sfvs_pkg::OffW'(j);
        found = 1'b1;
      end
    end
    lane_o.cnt = cnt;
    lane_o.off = off;
  end

endmodule

// ===== hw/rtl/sfvs_merge.sv =====
// Merge stage: picks the skew with the most invalid ways and forms the victim.
// Depends on sfvs_pkg.
`timescale 1ns / 1ps

module sfvs_merge (
  input  sfvs_pkg::lane_t                  lanes_i [sfvs_pkg::Skews],
  input  logic [sfvs_pkg::WayIdxW-1:0]     rnd_way_i,
  output sfvs_pkg::res_t                   res_o
);

  logic [sfvs_pkg::SkewIdxW-1:0] best;
  logic [sfvs_pkg::CntW-1:0]     best_cnt;
  logic [sfvs_pkg::WayIdxW-1:0]  inv_way;
  logic                          took;
  logic [sfvs_pkg::WayIdxW-1:0]  victim;

  always_comb begin
    best     = '0;
    best_cnt = lanes_i[0].cnt;
    // strict compare keeps the lowest skew on a tie
    for (int k = 1; k < sfvs_pkg::Skews; k++) begin
      if (lanes_i[k].cnt > best_cnt) begin
        best     = sfvs_pkg::SkewIdxW'(k);
        best_cnt = lanes_i[k].cnt;
      end
    end

    inv_way = '0;
    for (int k = 0; k < sfvs_pkg::Skews; k++) begin
      if (best == sfvs_pkg::SkewIdxW'(k)) begin
        inv_way = sfvs_pkg::WayIdxW'(k * sfvs_pkg::SkewSize)
                + sfvs_pkg::WayIdxW'(lanes_i[k].off);
      end
    end

    took   = (best_cnt != '0);
    victim = took ? inv_way : rnd_way_i;

    res_o.victim = sfvs_pkg::OutWayW'(victim);
    res_o.took   = took;
    res_o.skew   = sfvs_pkg::OutSkewW'(best);
  end

endmodule

// ===== hw/rtl/skew_fair_victim_select_core.sv =====
// Top level of the skew-fair victim selector for a skewed cache.
// Depends on sfvs_pkg, sfvs_lane and sfvs_merge.
`timescale 1ns / 1ps

// Victim way selection for a skewed cache. Each request item carries the
// valid bits of all candidate ways and a random way number. One lane per
// skew counts that skew's invalid ways and finds its lowest invalid way;
// the lane results are registered, then a merge stage picks the skew with
// the most invalid ways (lowest skew on a tie) and returns its lowest
// invalid way, or the random way (wrapped into range) when that skew has no
// invalid way. The block takes one item per cycle while the consumer does not
// stall; a result passes through the lane register, then the output register.
// A skid register behind the output register parks one item when the consumer
// stalls, so the block can keep taking items.

module skew_fair_victim_select_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [sfvs_pkg::MaskW-1:0]     valid_mask_i,
  input  logic [sfvs_pkg::RandW-1:0]     random_pick_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sfvs_pkg::OutWayW-1:0]   victim_way_o,
  output logic                           took_invalid_o,
  output logic [sfvs_pkg::OutSkewW-1:0]  chosen_skew_o
);

  // Mask widened to the way count; ways above the request field read as invalid.
  logic [sfvs_pkg::Ways-1:0] ext_mask;
  logic [sfvs_pkg::SkewSize-1:0] lane_mask [sfvs_pkg::Skews];
  sfvs_pkg::lane_t               lane_res  [sfvs_pkg::Skews];

  for (genvar i = 0; i < sfvs_pkg::Ways; i++) begin : g_ext
    if (i < sfvs_pkg::MaskW) begin : g_in
      assign ext_mask[i] = valid_mask_i[i];
    end else begin : g_hi
      assign ext_mask[i] = 1'b0;
    end
  end

  // Slice the mask into skews; slots past the last way act valid so they never count.
  for (genvar k = 0; k < sfvs_pkg::Skews; k++) begin : g_lane
    for (genvar j = 0; j < sfvs_pkg::SkewSize; j++) begin : g_slot
      if (k * sfvs_pkg::SkewSize + j < sfvs_pkg::Ways) begin : g_way
        assign lane_mask[k][j] = ext_mask[k * sfvs_pkg::SkewSize + j];
      end else begin : g_pad
        assign lane_mask[k][j] = 1'b1;
      end
    end

    sfvs_lane u_lane (
      .mask_i (lane_mask[k]),
      .lane_o (lane_res[k])
    );
  end

  // ---------------- stage 1: lane register ----------------
  sfvs_pkg::lane_t              lane_q [sfvs_pkg::Skews];
  logic [sfvs_pkg::WayIdxW-1:0] rnd_q;
  logic                         s1_valid_q, s1_valid_d;
  logic                         s1_load;
  logic                         s1_move;
  logic                         buf_ready;

  assign s1_move    = s1_valid_q && buf_ready;
  assign in_ready_o = !s1_valid_q || buf_ready;
  assign s1_load    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Payload holds unless a new item is loaded.
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      lane_q <= lane_res;
      rnd_q  <= sfvs_pkg::rnd_wrap(random_pick_i);
    end
  end

  // ---------------- stage 2: merge ----------------
  sfvs_pkg::res_t merged;

  sfvs_merge u_merge (
    .lanes_i   (lane_q),
    .rnd_way_i (rnd_q),
    .res_o     (merged)
  );

  // ---------------- output register with skid ----------------
  sfvs_pkg::res_t out_q, out_d;
  sfvs_pkg::res_t skid_q, skid_d;
  logic           out_valid_q, out_valid_d;
  logic           skid_valid_q, skid_valid_d;
  logic           pop;

  assign buf_ready = !skid_valid_q;
  assign pop       = out_valid_q && out_ready_i;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      // drain the skid entry into the output register
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (s1_move) begin
      if (!out_valid_q || pop) begin
        out_d       = merged;
        out_valid_d = 1'b1;
      end else begin
        // consumer stalled: park the item
        skid_d       = merged;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = out_valid_q;
  assign victim_way_o   = out_q.victim;
  assign took_invalid_o = out_q.took;
  assign chosen_skew_o  = out_q.skew;

endmodule
